// ----- hw/rtl/lsp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and reset values for the line sensor position block.
// Used by every file of the block; depends on nothing.
package lsp_pkg;

  localparam int WEIGHT_FRAC_BITS = 14;

  localparam int SENSOR_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int NUM_WEIGHTS = 6;
  localparam int WIDX_W     = 3;
  localparam int CNT_W      = 4;   // active position sensors, 0..12
  localparam int SUM_W      = WEIGHT_W + CNT_W;
  localparam int MAG_W      = SUM_W - 1;
  localparam int STEP_W     = $clog2(MAG_W + 1);
  localparam int TOTAL_W    = 5;   // active sensors of the whole row, 0..16
  localparam int CENTRE_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Sensor positions
  localparam int POS_FIRST  = 2;
  localparam int POS_LAST   = 13;
  localparam int LEFT_LAST  = 7;   // sensors up to here use the weight as is
  localparam int MIRROR_SUM = 13;  // sensor i on the right mirrors weight 13 - i
  localparam int LEFT_ZONE_LAST    = 5;
  localparam int CENTRE_ZONE_FIRST = 6;
  localparam int CENTRE_ZONE_LAST  = 9;
  localparam int RIGHT_ZONE_FIRST  = 10;
  localparam int ROW_LAST          = 15;

  // Junction detection
  localparam int JUNCTION_MIN_TOTAL = 5;
  localparam int ZONE_MIN_ACTIVE    = 2;
  localparam int HIT_CONFIRM        = 2;
  localparam int HIT_SAT            = 3;
  localparam int MISS_CLEAR         = 5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_S2         = 4'd0,
    CFG_WEIGHT_S3         = 4'd1,
    CFG_WEIGHT_S4         = 4'd2,
    CFG_WEIGHT_S5         = 4'd3,
    CFG_WEIGHT_S6         = 4'd4,
    CFG_WEIGHT_S7         = 4'd5,
    CFG_CENTRE_MAX_ACTIVE = 4'd6,
    CFG_CROSSLINE_MIN     = 4'd7
  } cfg_index_t;

  localparam logic [CENTRE_W-1:0] CENTRE_MAX_RESET    = 3'd2;
  localparam logic [TOTAL_W-1:0]  CROSSLINE_MIN_RESET = 5'd12;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t weight_arr_t [NUM_WEIGHTS];

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        active;
  } accum_res_t;

  // Hundredths scaled to the weight format, rounded to nearest, saturated.
  function automatic weight_t scaled_hundredths(longint unsigned h);
    longint unsigned v;
    v = ((h << WEIGHT_FRAC_BITS) + 64'd50) / 64'd100;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return weight_t'(v[WEIGHT_W-1:0]);
  endfunction

  localparam weight_t WEIGHT_RESET [NUM_WEIGHTS] = '{
    scaled_hundredths(35), scaled_hundredths(30), scaled_hundredths(30),
    scaled_hundredths(20), scaled_hundredths(8),  scaled_hundredths(5)
  };

endpackage

// ----- hw/rtl/lsp_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the line sensor position block: sample in,
// result out, register writes. Depends on lsp_pkg.
interface lsp_sample_if;
  logic valid;
  logic ready;
  logic [lsp_pkg::SENSOR_W-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lsp_result_if;
  logic valid;
  logic ready;
  logic signed [lsp_pkg::WEIGHT_W-1:0] line_position;
  logic line_seen;
  logic y_junction;
  logic crossline;

  modport source (output valid, output line_position, output line_seen,
                  output y_junction, output crossline, input ready);
  modport sink   (input valid, input line_position, input line_seen,
                  input y_junction, input crossline, output ready);
endinterface

interface lsp_cfg_if;
  logic valid;
  logic ready;
  logic [lsp_pkg::CFG_IDX_W-1:0]  index;
  logic [lsp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lsp_accum.sv -----
`timescale 1ns / 1ps
// Weighted sum of the active position sensors, one sensor per cycle through
// a single adder. Depends on lsp_pkg.
module lsp_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lsp_pkg::SENSOR_W-1:0]  bits,
  input  lsp_pkg::weight_arr_t          weights,
  output logic                          done,
  output lsp_pkg::accum_res_t           res
);

  localparam int CNT_W_L = lsp_pkg::CNT_W;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;
  logic [CNT_W_L-1:0] idx;

  logic [lsp_pkg::SENSOR_W-1:0] bits_q;
  logic                         right_side;
  logic [CNT_W_L-1:0]           widx_full;
  logic signed [lsp_pkg::SUM_W-1:0] ext;
  logic signed [lsp_pkg::SUM_W-1:0] addend;
  logic signed [lsp_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    right_side = (idx > CNT_W_L'(lsp_pkg::LEFT_LAST));
    widx_full  = right_side ? (CNT_W_L'(lsp_pkg::MIRROR_SUM) - idx)
                            : (idx - CNT_W_L'(lsp_pkg::POS_FIRST));
    ext        = lsp_pkg::SUM_W'(weights[widx_full[lsp_pkg::WIDX_W-1:0]]);
    addend     = right_side ? -ext : ext;
    sum_next   = res.sum + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            bits_q     <= bits;
            idx        <= CNT_W_L'(lsp_pkg::POS_FIRST);
            res.sum    <= '0;
            res.active <= '0;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (bits_q[idx]) begin
            res.sum    <= sum_next;
            res.active <= res.active + 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == CNT_W_L'(lsp_pkg::POS_LAST)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lsp_divider.sv -----
`timescale 1ns / 1ps
// Serial restoring divider: signed sum by active count, truncated toward
// zero, one quotient bit per cycle. Depends on lsp_pkg.
module lsp_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [lsp_pkg::SUM_W-1:0]   dividend,
  input  logic [lsp_pkg::CNT_W-1:0]          divisor,
  output logic                               done,
  output logic signed [lsp_pkg::WEIGHT_W-1:0] quotient
);

  localparam int MAG_W  = lsp_pkg::MAG_W;
  localparam int CNT_W  = lsp_pkg::CNT_W;
  localparam int STEP_W = lsp_pkg::STEP_W;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;
  logic [MAG_W-1:0]  q;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div;
  logic              neg;
  logic [STEP_W-1:0] step;

  logic [lsp_pkg::SUM_W-1:0] mag_full;
  logic [CNT_W:0]            shifted;
  logic                      ge;
  logic [CNT_W:0]            diff;
  logic [MAG_W-1:0]          q_next;
  logic [MAG_W-1:0]          q_signed;

  always_comb begin
    mag_full = dividend[lsp_pkg::SUM_W-1] ? (-dividend) : dividend;
    shifted  = {rem, q[MAG_W-1]};
    ge       = (shifted >= {1'b0, div});
    diff     = shifted - {1'b0, div};
    q_next   = {q[MAG_W-2:0], ge};
    q_signed = neg ? (-q_next) : q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            q     <= mag_full[MAG_W-1:0];
            rem   <= '0;
            div   <= divisor;
            neg   <= dividend[lsp_pkg::SUM_W-1];
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          q    <= q_next;
          rem  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
          step <= step + 1'b1;
          if (step == STEP_W'(MAG_W - 1)) begin
            // the mean, cut to the weight width
            quotient <= q_signed[lsp_pkg::WEIGHT_W-1:0];
            done     <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/line_sensor_position_and_junction.sv -----
`timescale 1ns / 1ps
// Line sensor position and junction detector. One 16-bit sample is taken
// when the block is idle; the weighted sum of sensors 2 to 13 is built one
// sensor per cycle, then divided by the active count in a serial divider at
// one quotient bit per cycle; a sample with no active position sensor skips
// the divider and keeps the last position. The result sits in an output
// register, so the next sample is accepted the cycle after the result is
// loaded, while it waits to be taken. Register writes are always taken and
// belong in idle time. Depends on lsp_pkg, lsp_if, lsp_accum and lsp_divider.
module line_sensor_position_and_junction (
  input  logic                 clk,
  input  logic                 rst,
  lsp_sample_if.sink           sample,
  lsp_result_if.source         result,
  lsp_cfg_if.sink              cfg
);

  typedef enum logic [1:0] {ST_IDLE, ST_ACCUM, ST_DIVIDE, ST_FINISH} state_t;

  localparam int TOTAL_W  = lsp_pkg::TOTAL_W;
  localparam int CENTRE_W = lsp_pkg::CENTRE_W;

  state_t state;

  lsp_pkg::weight_arr_t         weights;
  logic [CENTRE_W-1:0]          centre_max;
  logic [TOTAL_W-1:0]           crossline_min;

  logic [lsp_pkg::SENSOR_W-1:0] bits_q;
  logic signed [lsp_pkg::WEIGHT_W-1:0] held_position;
  logic                         seen;
  logic [1:0]                   hit_run;
  logic [2:0]                   miss_run;
  logic                         junction_stable;

  logic                         sample_take;
  logic                         accum_done;
  lsp_pkg::accum_res_t          accum_res;
  logic                         div_start;
  logic                         div_done;
  logic signed [lsp_pkg::WEIGHT_W-1:0] div_quot;

  logic [TOTAL_W-1:0] total, left, centre, right;
  logic               raw_hit;
  logic [1:0]         hit_run_next;
  logic [2:0]         miss_run_next;
  logic               junction_next;
  logic               out_free;

  function automatic logic [TOTAL_W-1:0] count_bits(
    logic [lsp_pkg::SENSOR_W-1:0] v, int lo, int hi);
    logic [TOTAL_W-1:0] n;
    n = '0;
    for (int i = 0; i < lsp_pkg::SENSOR_W; i++) begin
      if (i >= lo && i <= hi && v[i]) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  assign sample.ready = (state == ST_IDLE);
  assign sample_take  = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;
  assign div_start    = (state == ST_ACCUM) && accum_done && (accum_res.active != '0);
  assign out_free     = !result.valid || result.ready;

  lsp_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .start   (sample_take),
    .bits    (sample.sensor_bits),
    .weights (weights),
    .done    (accum_done),
    .res     (accum_res)
  );

  lsp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (accum_res.sum),
    .divisor  (accum_res.active),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    total  = count_bits(bits_q, 0, lsp_pkg::ROW_LAST);
    left   = count_bits(bits_q, 0, lsp_pkg::LEFT_ZONE_LAST);
    centre = count_bits(bits_q, lsp_pkg::CENTRE_ZONE_FIRST, lsp_pkg::CENTRE_ZONE_LAST);
    right  = count_bits(bits_q, lsp_pkg::RIGHT_ZONE_FIRST, lsp_pkg::ROW_LAST);
    raw_hit = (total >= TOTAL_W'(lsp_pkg::JUNCTION_MIN_TOTAL)) &&
              (left >= TOTAL_W'(lsp_pkg::ZONE_MIN_ACTIVE)) &&
              (right >= TOTAL_W'(lsp_pkg::ZONE_MIN_ACTIVE)) &&
              (centre <= TOTAL_W'(centre_max));
    junction_next = junction_stable;
    if (raw_hit) begin
      hit_run_next  = (hit_run < 2'(lsp_pkg::HIT_SAT)) ? hit_run + 1'b1 : hit_run;
      miss_run_next = '0;
      if (hit_run_next >= 2'(lsp_pkg::HIT_CONFIRM)) begin
        junction_next = 1'b1;
      end
    end else begin
      hit_run_next  = '0;
      miss_run_next = (miss_run < 3'(lsp_pkg::MISS_CLEAR)) ? miss_run + 1'b1 : miss_run;
      if (miss_run_next >= 3'(lsp_pkg::MISS_CLEAR)) begin
        junction_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      weights         <= lsp_pkg::WEIGHT_RESET;
      centre_max      <= lsp_pkg::CENTRE_MAX_RESET;
      crossline_min   <= lsp_pkg::CROSSLINE_MIN_RESET;
      held_position   <= '0;
      hit_run         <= '0;
      miss_run        <= '0;
      junction_stable <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lsp_pkg::CFG_WEIGHT_S2, lsp_pkg::CFG_WEIGHT_S3, lsp_pkg::CFG_WEIGHT_S4,
          lsp_pkg::CFG_WEIGHT_S5, lsp_pkg::CFG_WEIGHT_S6, lsp_pkg::CFG_WEIGHT_S7:
            weights[cfg.index[lsp_pkg::WIDX_W-1:0]] <= lsp_pkg::weight_t'(cfg.data);
          lsp_pkg::CFG_CENTRE_MAX_ACTIVE: centre_max    <= cfg.data[CENTRE_W-1:0];
          lsp_pkg::CFG_CROSSLINE_MIN:     crossline_min <= cfg.data[TOTAL_W-1:0];
          default: ;  // drop writes beyond the register list
        endcase
      end

      // a new result loaded in the finish state replaces the one taken
      if (result.valid && result.ready && state != ST_FINISH) begin
        result.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_take) begin
            bits_q <= sample.sensor_bits;
            state  <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (accum_done) begin
            seen  <= (accum_res.active != '0);
            // no active position sensor: hold the last position
            state <= (accum_res.active != '0) ? ST_DIVIDE : ST_FINISH;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            held_position <= div_quot;
            state         <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            hit_run              <= hit_run_next;
            miss_run             <= miss_run_next;
            junction_stable      <= junction_next;
            result.valid         <= 1'b1;
            result.line_position <= held_position;
            result.line_seen     <= seen;
            result.y_junction    <= junction_next;
            result.crossline     <= (total >= crossline_min);
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/lsp_track_monitor.sv -----
`timescale 1ns / 1ps
// Monitor for the line sensor position block: tracks register writes, predicts
// one track report per accepted sample and compares it with the result channel.
// Depends on lsp_pkg and the channel interfaces in lsp_if.
module lsp_track_monitor
  import lsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  lsp_sample_if  smp,
  lsp_result_if  res,
  lsp_cfg_if     cfg,
  output int     failures,
  output int     outstanding
);

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] position;
    logic                       seen;
    logic                       junction;
    logic                       crossline;
  } track_report_t;

  // Q2.14 weights of sensors 2 to 7 out of reset
  localparam weight_t WEIGHT_DEFAULT [NUM_WEIGHTS] = '{
    16'sd5734, 16'sd4915, 16'sd4915, 16'sd3277, 16'sd1311, 16'sd819
  };
  localparam int CENTRE_LIMIT_DEFAULT = 2;
  localparam int CROSS_LIMIT_DEFAULT  = 12;

  weight_t                     sensor_weight [NUM_WEIGHTS];
  logic [CENTRE_W-1:0]         centre_limit;
  logic [TOTAL_W-1:0]          cross_limit;
  logic signed [WEIGHT_W-1:0]  held_pos;
  logic [1:0]                  hit_run;
  logic [2:0]                  miss_run;
  logic                        junction_on;
  track_report_t               queued_reports [$];

  task automatic flag_mismatch(input string what, input int got, input int want_v);
    $display("%0t ns: %s: got %0d, predicted %0d", $time, what, got, want_v);
    failures++;
  endtask

  function automatic track_report_t estimate_track(input logic [SENSOR_W-1:0] bits);
    int            sum;
    int            active;
    int            total;
    int            left;
    int            centre;
    int            right;
    logic          raw_hit;
    track_report_t rpt;
    sum    = 0;
    active = 0;
    for (int i = POS_FIRST; i <= POS_LAST; i++) begin
      if (bits[i]) begin
        // right half mirrors the left weights with the sign flipped
        if (i <= LEFT_LAST) begin
          sum += sensor_weight[WIDX_W'(i - POS_FIRST)];
        end else begin
          sum -= sensor_weight[WIDX_W'(MIRROR_SUM - i)];
        end
        active++;
      end
    end
    if (active > 0) begin
      held_pos = WEIGHT_W'(sum / active);
    end

    total  = $countones(bits);
    left   = $countones(bits[LEFT_ZONE_LAST:0]);
    centre = $countones(bits[CENTRE_ZONE_LAST:CENTRE_ZONE_FIRST]);
    right  = $countones(bits[ROW_LAST:RIGHT_ZONE_FIRST]);
    raw_hit = (total >= JUNCTION_MIN_TOTAL) && (left >= ZONE_MIN_ACTIVE) &&
              (right >= ZONE_MIN_ACTIVE) && (centre <= int'(centre_limit));

    if (raw_hit) begin
      if (hit_run < HIT_SAT) begin
        hit_run++;
      end
      miss_run = '0;
      if (hit_run >= HIT_CONFIRM) begin
        junction_on = 1'b1;
      end
    end else begin
      hit_run = '0;
      if (miss_run < MISS_CLEAR) begin
        miss_run++;
      end
      if (miss_run >= MISS_CLEAR) begin
        junction_on = 1'b0;
      end
    end

    rpt.position  = held_pos;
    rpt.seen      = (active > 0);
    rpt.junction  = junction_on;
    rpt.crossline = (total >= int'(cross_limit));
    return rpt;
  endfunction

  always @(posedge clk) begin : watch
    track_report_t want;
    if (rst) begin
      sensor_weight = WEIGHT_DEFAULT;
      centre_limit = CENTRE_W'(CENTRE_LIMIT_DEFAULT);
      cross_limit  = TOTAL_W'(CROSS_LIMIT_DEFAULT);
      held_pos     = '0;
      hit_run      = '0;
      miss_run     = '0;
      junction_on  = 1'b0;
      queued_reports.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WEIGHT_S2, CFG_WEIGHT_S3, CFG_WEIGHT_S4,
          CFG_WEIGHT_S5, CFG_WEIGHT_S6, CFG_WEIGHT_S7: begin
            sensor_weight[WIDX_W'(cfg.index - CFG_WEIGHT_S2)] = cfg.data;
          end
          CFG_CENTRE_MAX_ACTIVE: centre_limit = cfg.data[CENTRE_W-1:0];
          CFG_CROSSLINE_MIN:     cross_limit  = cfg.data[TOTAL_W-1:0];
          default: ;  // drop writes past the register list
        endcase
      end
      if (smp.valid && smp.ready) begin
        queued_reports.push_back(estimate_track(smp.sensor_bits));
      end
      if (res.valid && res.ready) begin
        if (queued_reports.size() == 0) begin
          flag_mismatch("result transaction with no sample pending, position",
                        res.line_position, 0);
        end else begin
          want = queued_reports.pop_front();
          if (res.line_position !== want.position) begin
            flag_mismatch("line_position", res.line_position, want.position);
          end
          if (res.line_seen !== want.seen) begin
            flag_mismatch("line_seen", res.line_seen, want.seen);
          end
          if (res.y_junction !== want.junction) begin
            flag_mismatch("y_junction", res.y_junction, want.junction);
          end
          if (res.crossline !== want.crossline) begin
            flag_mismatch("crossline", res.crossline, want.crossline);
          end
        end
      end
    end
    outstanding <= queued_reports.size();
  end

endmodule

// ----- dv/tb_line_sensor_position_and_junction.sv -----
`timescale 1ns / 1ps
// Top of the line sensor position testbench: clock, reset, sample and register
// stimulus under several idling phases, and the verdict. Depends on lsp_pkg,
// lsp_if, the block and lsp_track_monitor.
module tb_line_sensor_position_and_junction;
  import lsp_pkg::*;

  typedef enum int {
    SHAPE_FORK,   // left and right branches, sparse centre
    SHAPE_LINE,   // narrow line of one to three sensors
    SHAPE_NOISE,
    SHAPE_BAR,    // dense row, mostly a cross line
    SHAPE_BLANK   // outer sensors only, or nothing
  } sample_shape_t;

  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 205;
  localparam int SQUEEZE_ITEMS    = 40;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 500000;

  // Extremes, lone edge sensors, then a Y-junction that is confirmed, cleared
  // by a run of misses (centre too busy) and confirmed again
  localparam logic [SENSOR_W-1:0] DIRECTED_SAMPLES [23] = '{
    16'h0000, 16'hFFFF, 16'h0004, 16'h2000, 16'h0003, 16'hC000, 16'h0180,
    16'h5555, 16'hAAAA,
    16'h181C, 16'h181C, 16'h181C,
    16'h19DC, 16'h19DC, 16'h19DC, 16'h19DC, 16'h19DC,
    16'h181C, 16'h0000, 16'h181C, 16'h181C,
    16'h0FFF, 16'h07FF
  };

  logic clk;
  logic rst;
  logic hold_off;
  int   send_idle_pct;
  int   take_stall_pct;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  event squeeze_start;

  lsp_sample_if smp ();
  lsp_result_if res ();
  lsp_cfg_if    cfg ();

  line_sensor_position_and_junction DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg)
  );

  lsp_track_monitor u_track_monitor (
    .clk         (clk),
    .rst         (rst),
    .smp         (smp),
    .res         (res),
    .cfg         (cfg),
    .failures    (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_sensor_position_and_junction verification failed");
    $finish;
  end

  initial begin : result_taker
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= !hold_off && ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input
  initial begin : hold_off_ctl
    int held;
    hold_off <= 1'b0;
    @(squeeze_start);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
      @(posedge clk);
    end
    hold_off <= 1'b0;
  end

  task automatic send_sample(input logic [SENSOR_W-1:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid       <= 1'b1;
    smp.sensor_bits <= bits;
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic configure(input int phase);
    logic [CFG_DATA_W-1:0] value;
    for (int k = 0; k < NUM_WEIGHTS; k++) begin
      case (phase)
        1:       value = 16'sd16384;
        2:       value = -16'sd16384;
        3:       value = (k % 2) ? 16'h7FFF : 16'h8000;
        5:       value = 16'($urandom);
        default: value = 16'($urandom_range(32768) - 16384);
      endcase
      write_reg(CFG_IDX_W'(CFG_WEIGHT_S2 + k), value);
    end
    case (phase)
      1:       value = 16'd0;
      2:       value = 16'd4;
      3:       value = 16'd7;
      5:       value = 16'($urandom);
      default: value = 16'($urandom_range(7));
    endcase
    write_reg(CFG_CENTRE_MAX_ACTIVE, value);
    case (phase)
      1:       value = 16'd0;
      2:       value = 16'd16;
      3:       value = 16'd31;
      5:       value = 16'($urandom);
      default: value = 16'($urandom_range(31));
    endcase
    write_reg(CFG_CROSSLINE_MIN, value);
    if (phase >= 3) begin
      write_reg(CFG_IDX_W'(CFG_CROSSLINE_MIN + 1 +
                           $urandom_range((1 << CFG_IDX_W) - 2 - CFG_CROSSLINE_MIN)),
                16'($urandom));
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic sample_shape_t pick_shape();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return SHAPE_FORK;
    if (roll < 65) return SHAPE_LINE;
    if (roll < 80) return SHAPE_NOISE;
    if (roll < 90) return SHAPE_BAR;
    return SHAPE_BLANK;
  endfunction

  function automatic logic [SENSOR_W-1:0] make_sample(input sample_shape_t shape);
    logic [5:0]          left_zone;
    logic [5:0]          right_zone;
    logic [3:0]          centre_zone;
    int                  width;
    logic [SENSOR_W-1:0] bits;
    case (shape)
      SHAPE_FORK: begin
        do begin
          left_zone   = 6'($urandom_range(63));
          right_zone  = 6'($urandom_range(63));
          centre_zone = 4'($urandom_range(15) & $urandom_range(15));
        end while ($countones(left_zone) < ZONE_MIN_ACTIVE ||
                   $countones(right_zone) < ZONE_MIN_ACTIVE ||
                   $countones({right_zone, centre_zone, left_zone}) < JUNCTION_MIN_TOTAL);
        bits = {right_zone, centre_zone, left_zone};
      end
      SHAPE_LINE: begin
        width = $urandom_range(3, 1);
        bits  = SENSOR_W'(((1 << width) - 1) << $urandom_range(SENSOR_W - width));
      end
      SHAPE_BAR: begin
        bits = 16'($urandom) | 16'($urandom) | 16'($urandom);
      end
      SHAPE_BLANK: begin
        bits = {2'($urandom_range(3)), 12'd0, 2'($urandom_range(3))};
      end
      default: bits = 16'($urandom);
    endcase
    return bits;
  endfunction

  // Runs of one shape so the junction debounce sees real hit and miss streaks
  task automatic send_random(input int count);
    int            sent;
    int            run;
    sample_shape_t shape;
    sent = 0;
    while (sent < count) begin
      shape = pick_shape();
      run   = $urandom_range(6, 1);
      repeat (run) begin
        send_sample(make_sample(shape));
        sent++;
      end
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct <= 0;  take_stall_pct <= 0;  end
      1: begin send_idle_pct <= 55; take_stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  take_stall_pct <= 55; end
      default: begin send_idle_pct <= 27; take_stall_pct <= 27; end
    endcase
  endtask

  initial begin : stimulus
    int phase;
    rst             <= 1'b1;
    smp.valid       <= 1'b0;
    smp.sensor_bits <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    send_idle_pct   <= 0;
    take_stall_pct  <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        configure(phase);
      end
      set_idling(phase % 4);
      if (phase == 0) begin
        foreach (DIRECTED_SAMPLES[i]) begin
          send_sample(DIRECTED_SAMPLES[i]);
        end
      end
      if (phase == 4) begin
        -> squeeze_start;
        repeat (SQUEEZE_ITEMS) send_sample(make_sample(pick_shape()));
      end
      send_random(RANDOM_PER_PHASE);
      smp.valid <= 1'b0;
      // hold further writes until every report is back
      do @(posedge clk); while (outstanding != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("line_sensor_position_and_junction verification clean");
    end else begin
      $display("line_sensor_position_and_junction verification failed");
    end
    $finish;
  end

endmodule

// ----- line_sensor_position_and_junction.f -----
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_if.sv
hw/rtl/lsp_accum.sv
hw/rtl/lsp_divider.sv
hw/rtl/line_sensor_position_and_junction.sv
dv/lsp_track_monitor.sv
dv/tb_line_sensor_position_and_junction.sv
